@@ hw/rtl/avt_pkg.sv @@
// Shared types and constants for the adaptive view timeout block.
package avt_pkg;

    localparam int unsigned TIME_W    = 64;
    localparam int unsigned CFG_IDX_W = 2;

    typedef enum logic [1:0] {
        CMD_CHECK = 2'd0,
        CMD_START = 2'd1,
        CMD_END   = 2'd2,
        CMD_NOP   = 2'd3
    } t_cmd;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GUARD_VIEW     = 2'd0,
        CFG_MAX_LENGTH     = 2'd1,
        CFG_INITIAL_LENGTH = 2'd2,
        CFG_UNUSED         = 2'd3
    } t_cfg_idx;

    localparam logic [TIME_W-1:0] RST_GUARD_VIEW     = 64'd0;
    localparam logic [TIME_W-1:0] RST_MAX_LENGTH     = 64'd1000000;
    localparam logic [TIME_W-1:0] RST_INITIAL_LENGTH = 64'd100000;

    typedef struct packed {
        logic [1:0]        cmd;
        logic [TIME_W-1:0] now_time;
        logic [TIME_W-1:0] view_number;
    } t_in_word;

    typedef struct packed {
        logic              timed_out;
        logic [TIME_W-1:0] length_now;
    } t_out_word;

    typedef struct packed {
        logic [TIME_W-1:0] guard_view;
        logic [TIME_W-1:0] max_length;
        logic [TIME_W-1:0] initial_length;
    } t_cfg;

endpackage

@@ hw/rtl/avt_stream_if.sv @@
// Valid/ready stream interface that carries one word per handshake.
interface avt_stream_if #(
    parameter type t_word = logic
);
    logic  valid;
    logic  ready;
    t_word payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

@@ hw/rtl/avt_cfg_regs.sv @@
// Configuration registers with a load strobe for the initial timer length.
module avt_cfg_regs (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [avt_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [avt_pkg::TIME_W-1:0]          i_cfg_data,
    output avt_pkg::t_cfg                       o_cfg,
    output logic                                o_load_len
);
    avt_pkg::t_cfg r_cfg;
    logic          r_load_len;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.guard_view     <= avt_pkg::RST_GUARD_VIEW;
            r_cfg.max_length     <= avt_pkg::RST_MAX_LENGTH;
            r_cfg.initial_length <= avt_pkg::RST_INITIAL_LENGTH;
            r_load_len           <= 1'b0;
        end else begin
            r_load_len <= 1'b0;
            if (i_cfg_we) begin
                unique case (avt_pkg::t_cfg_idx'(i_cfg_idx))
                    avt_pkg::CFG_GUARD_VIEW:     r_cfg.guard_view <= i_cfg_data;
                    avt_pkg::CFG_MAX_LENGTH:     r_cfg.max_length <= i_cfg_data;
                    avt_pkg::CFG_INITIAL_LENGTH: begin
                        r_cfg.initial_length <= i_cfg_data;
                        r_load_len           <= 1'b1;
                    end
                    default: ;
                endcase
            end
        end
    end

    assign o_cfg      = r_cfg;
    assign o_load_len = r_load_len;
endmodule

@@ hw/rtl/avt_core.sv @@
// Timer state and the per-word update for check, start and end commands.
module avt_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  avt_pkg::t_in_word   i_word,
    input  avt_pkg::t_cfg       i_cfg,
    input  logic                i_load_len,
    output avt_pkg::t_out_word  o_result
);
    localparam int unsigned W = avt_pkg::TIME_W;

    logic         r_armed;
    logic [W-1:0] r_start_stamp;
    logic [W-1:0] r_expiry_stamp;
    logic [W-1:0] r_cur_length;
    logic [W-1:0] r_growth_step;
    logic [W-1:0] r_last_view;

    logic         n_armed;
    logic [W-1:0] n_start_stamp;
    logic [W-1:0] n_expiry_stamp;
    logic [W-1:0] n_cur_length;
    logic [W-1:0] n_growth_step;
    logic [W-1:0] n_last_view;

    logic         fire;
    logic [W-1:0] step_eff;
    logic [W:0]   grow_sum;
    logic [W-1:0] grown;
    logic [W-1:0] elapsed;

    always_comb begin
        fire = (i_word.view_number >= i_cfg.guard_view) && r_armed
            && (i_word.now_time > r_expiry_stamp);
        step_eff = (r_last_view < (i_word.view_number - {{(W-1){1'b0}}, 1'b1}))
            ? r_cur_length : r_growth_step;
        grow_sum = {1'b0, r_cur_length} + {1'b0, step_eff};
        grown    = (grow_sum[W] || (grow_sum[W-1:0] > i_cfg.max_length))
            ? i_cfg.max_length : grow_sum[W-1:0];
        elapsed  = i_word.now_time - r_start_stamp;

        n_armed        = r_armed;
        n_start_stamp  = r_start_stamp;
        n_expiry_stamp = r_expiry_stamp;
        n_cur_length   = r_cur_length;
        n_growth_step  = r_growth_step;
        n_last_view    = r_last_view;

        case (avt_pkg::t_cmd'(i_word.cmd))
            avt_pkg::CMD_CHECK: begin
                if (fire) begin
                    n_armed       = 1'b0;
                    n_growth_step = step_eff;
                    n_cur_length  = grown;
                    n_last_view   = i_word.view_number;
                end
            end
            avt_pkg::CMD_START: begin
                n_armed        = 1'b1;
                n_start_stamp  = i_word.now_time;
                n_expiry_stamp = i_word.now_time + r_cur_length;
            end
            avt_pkg::CMD_END: begin
                if (r_armed && (elapsed < (r_cur_length >> 2))) begin
                    n_cur_length = r_cur_length >> 1;
                end
                n_armed = 1'b0;
            end
            default: ;
        endcase

        o_result.timed_out  = (avt_pkg::t_cmd'(i_word.cmd) == avt_pkg::CMD_CHECK) && fire;
        o_result.length_now = n_cur_length;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_armed        <= 1'b0;
            r_start_stamp  <= '0;
            r_expiry_stamp <= '0;
            r_cur_length   <= avt_pkg::RST_INITIAL_LENGTH;
            r_growth_step  <= avt_pkg::RST_INITIAL_LENGTH;
            r_last_view    <= '0;
        end else if (i_load_len) begin
            r_cur_length  <= i_cfg.initial_length;
            r_growth_step <= i_cfg.initial_length;
        end else if (i_valid) begin
            r_armed        <= n_armed;
            r_start_stamp  <= n_start_stamp;
            r_expiry_stamp <= n_expiry_stamp;
            r_cur_length   <= n_cur_length;
            r_growth_step  <= n_growth_step;
            r_last_view    <= n_last_view;
        end
    end

    a_timeout_disarms: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !i_load_len && o_result.timed_out) |=> !r_armed)
        else $error("Timer still armed after a timeout.");

    a_start_arms: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !i_load_len && (i_word.cmd == avt_pkg::CMD_START))
        |=> (r_armed && (r_start_stamp == $past(i_word.now_time))))
        else $error("Start did not arm the timer with the new start time.");

    a_timeout_only_on_check: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.timed_out |-> (r_armed && (i_word.cmd == avt_pkg::CMD_CHECK)))
        else $error("Timeout reported outside an armed check.");
endmodule

@@ hw/rtl/adaptive_view_timeout.sv @@
// Top level of the adaptive view timeout: input register, core and result register.
//
//  channel     dir  handshake      word
//  i_in_word   in   valid/ready    cmd, now_time, view_number
//  o_out_word  out  valid/ready    timed_out, length_now
//  i_cfg_*     in   write enable   register index, 64-bit data
//
// A word passes through the input register and then the result register;
// one word per cycle is sustained while the output is not stalled.
// The core updates the timer state as the word leaves the input register.
// Reset is synchronous; the timer state and valid flags take their reset values, the word registers are not reset.
// While a result waits, the input register still takes one more word; ready
// drops only when both registers are full and the output is stalled.
module adaptive_view_timeout (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    avt_stream_if.sink                    i_in_word,
    avt_stream_if.source                  o_out_word,
    input  logic                          i_cfg_we,
    input  logic [avt_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [avt_pkg::TIME_W-1:0]    i_cfg_data
);
    logic               r_in_valid;
    avt_pkg::t_in_word  r_in_word;
    logic               r_out_valid;
    avt_pkg::t_out_word r_out_word;

    logic               advance;
    avt_pkg::t_cfg      cfg;
    logic               load_len;
    avt_pkg::t_out_word core_result;

    assign advance         = r_in_valid && (!r_out_valid || o_out_word.ready);
    assign i_in_word.ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_in_word.ready) begin
                r_in_valid <= i_in_word.valid;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (o_out_word.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_word.ready && i_in_word.valid) begin
            r_in_word <= i_in_word.payload;
        end
        if (advance) begin
            r_out_word <= core_result;
        end
    end

    avt_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg),
        .o_load_len (load_len)
    );

    avt_core u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (advance),
        .i_word     (r_in_word),
        .i_cfg      (cfg),
        .i_load_len (load_len),
        .o_result   (core_result)
    );

    assign o_out_word.valid   = r_out_valid;
    assign o_out_word.payload = r_out_word;

    a_word_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !advance) |=> r_in_valid)
        else $error("Word in the input register dropped without moving on.");

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> r_out_valid)
        else $error("Processed word did not reach the result register.");
endmodule
